@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL; signed_int_to_decimal_ascii_core.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i while rst_ni is high.
`define ITD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define ITD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/itd_pkg.sv @@
package itd_pkg;

  // Default width of the signed input number.
  localparam int unsigned NUMBER_BITS = 32;

  // ASCII codes used by the datapath and by the character checks.
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } itd_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic conv_step;
    logic skip_step;
    logic emit_sign;
    logic emit_digit;
  } itd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_last;
    logic neg;
    logic top_zero;
    logic one_left;
    logic out_free;
  } itd_stat_t;

endpackage

@@ hw/rtl/itd_ctrl.sv @@
module itd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  itd_pkg::itd_stat_t  stat_i,
  output itd_pkg::itd_cmd_t   cmd_o
);

  itd_pkg::itd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      itd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = itd_pkg::ST_CONV;
      end
      itd_pkg::ST_CONV: begin
        if (stat_i.conv_last) state_d = stat_i.neg ? itd_pkg::ST_SIGN : itd_pkg::ST_SKIP;
      end
      itd_pkg::ST_SIGN: begin
        if (stat_i.out_free) state_d = itd_pkg::ST_SKIP;
      end
      itd_pkg::ST_SKIP: begin
        if (!stat_i.top_zero || stat_i.one_left) state_d = itd_pkg::ST_EMIT;
      end
      itd_pkg::ST_EMIT: begin
        if (stat_i.out_free && stat_i.one_left) state_d = itd_pkg::ST_IDLE;
      end
      default: state_d = itd_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      itd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      itd_pkg::ST_CONV: begin
        cmd_o.conv_step = 1'b1;
      end
      itd_pkg::ST_SIGN: begin
        cmd_o.emit_sign = stat_i.out_free;
      end
      itd_pkg::ST_SKIP: begin
        cmd_o.skip_step = stat_i.top_zero && !stat_i.one_left;
      end
      itd_pkg::ST_EMIT: begin
        cmd_o.emit_digit = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/itd_dp.sv @@
module itd_dp #(
  parameter int unsigned NumberBits = itd_pkg::NUMBER_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [NumberBits-1:0] number_i,
  input  logic                         out_ready_i,
  input  itd_pkg::itd_cmd_t            cmd_i,
  output itd_pkg::itd_stat_t           stat_o,
  output logic [7:0]                   character_o,
  output logic                         last_o,
  output logic                         out_valid_o
);

  // Decimal digits needed for any magnitude of NumberBits bits (log10(2) ~ 1233/4096).
  localparam int unsigned Digits = (NumberBits * 1233) / 4096 + 1;
  localparam int unsigned BcdW   = Digits * 4;
  localparam int unsigned CntW   = $clog2(Digits + 1);
  localparam int unsigned BitW   = $clog2(NumberBits);

  logic [BcdW-1:0]            bcd_q, bcd_d, bcd_adj;
  logic [NumberBits-1:0]      bin_q, bin_d, num_u, mag;
  logic [BcdW+NumberBits-1:0] shifted;
  logic [BitW-1:0]            bit_q, bit_d;
  logic [CntW-1:0]            dig_q, dig_d;
  logic                       neg_q, neg_d;
  logic [7:0]                 char_q, char_d;
  logic                       last_q, last_d;
  logic                       ovalid_q, ovalid_d;

  assign num_u = number_i;
  assign mag   = num_u[NumberBits-1] ? NumberBits'(~num_u + 1'b1) : num_u;

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    logic [3:0] nib;
    for (int i = 0; i < Digits; i++) begin
      nib = bcd_q[4*i +: 4];
      bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  assign shifted = {bcd_adj, bin_q} << 1;

  always_comb begin
    bcd_d    = bcd_q;
    bin_d    = bin_q;
    bit_d    = bit_q;
    dig_d    = dig_q;
    neg_d    = neg_q;
    char_d   = char_q;
    last_d   = last_q;
    ovalid_d = ovalid_q && !out_ready_i;
    if (cmd_i.load) begin
      bcd_d = '0;
      bin_d = mag;
      bit_d = '0;
      dig_d = CntW'(Digits);
      neg_d = num_u[NumberBits-1];
    end
    if (cmd_i.conv_step) begin
      bcd_d = shifted[BcdW+NumberBits-1 -: BcdW];
      bin_d = shifted[NumberBits-1:0];
      bit_d = bit_q + 1'b1;
    end
    if (cmd_i.skip_step) begin
      bcd_d = bcd_q << 4;
      dig_d = dig_q - 1'b1;
    end
    if (cmd_i.emit_sign) begin
      char_d   = itd_pkg::CHAR_MINUS;
      last_d   = 1'b0;
      ovalid_d = 1'b1;
    end
    if (cmd_i.emit_digit) begin
      char_d   = {itd_pkg::CHAR_DIGIT_HI, bcd_q[BcdW-1 -: 4]};
      last_d   = (dig_q == CntW'(1));
      bcd_d    = bcd_q << 4;
      dig_d    = dig_q - 1'b1;
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q    <= '0;
      dig_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      bit_q    <= bit_d;
      dig_q    <= dig_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    bin_q  <= bin_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign stat_o.conv_last = (bit_q == BitW'(NumberBits - 1));
  assign stat_o.neg       = neg_q;
  assign stat_o.top_zero  = (bcd_q[BcdW-1 -: 4] == 4'd0);
  assign stat_o.one_left  = (dig_q == CntW'(1));
  assign stat_o.out_free  = !ovalid_q || out_ready_i;

  assign character_o = char_q;
  assign last_o      = last_q;
  assign out_valid_o = ovalid_q;

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii_core.sv @@
// Channel | Direction | Signals                              | Beat
// input   | in        | in_valid_i, in_ready_o, number_i      | one signed number
// output  | out       | out_valid_o, out_ready_i, character_o | one ASCII character
//         |           | last_o                                | (last_o on the final one)
// Each item runs through the double-dabble loop, which shifts in one magnitude bit per cycle,
// then the minus sign if the number is negative, then the leading-zero skip, which drops one
// BCD digit per cycle, and last the digit emission.
// Reset (rst_ni low, asynchronous) returns the controller to idle and empties the output register.
// A stall on the output holds the controller in the sign or digit state; no character is lost.

`include "assert_macros.svh"

module signed_int_to_decimal_ascii_core #(
  parameter int unsigned NumberBits = itd_pkg::NUMBER_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [NumberBits-1:0] number_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   character_o,
  output logic                         last_o
);

  itd_pkg::itd_cmd_t  cmd;
  itd_pkg::itd_stat_t stat;
  logic               char_legal;

  // The controller sequences load, conversion, sign, leading-zero skip and
  // digit emission. It only takes a new number once the previous text has
  // been handed to the output register.
  itd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath takes the magnitude of the number (the most negative value
  // maps to 2^(NumberBits-1), which still fits unsigned), converts it to BCD
  // with shift-and-add-three, then shifts digits out from the top.
  itd_dp #(
    .NumberBits (NumberBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .number_i    (number_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .character_o (character_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o)
  );

  // A legal character is a minus sign that never ends the text, or a decimal digit.
  assign char_legal = (character_o == itd_pkg::CHAR_MINUS && !last_o) ||
                      (character_o >= itd_pkg::CHAR_ZERO && character_o <= itd_pkg::CHAR_NINE);

  // While the block is ready for a number, nothing is written to the output.
  `ITD_ASSERT(a_idle_no_emit, in_ready_o |-> !(cmd.emit_sign || cmd.emit_digit), "emit while idle")

  // A number is accepted at most once before the conversion starts.
  `ITD_ASSERT(a_accept_then_busy, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")

  // Every valid character is a minus sign or a decimal digit.
  `ITD_ASSERT(a_char_legal, out_valid_o |-> char_legal, "bad character")

  // A clock edge taken in reset leaves the output register empty.
  `ITD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "output valid in reset")

endmodule

@@ dv/signed_int_to_decimal_ascii_core_tb.sv @@
module signed_int_to_decimal_ascii_core_tb;

  localparam int NB = itd_pkg::NUMBER_BITS;
  // Room for the digits of the widest magnitude the block can see.
  localparam int DigitRoom = 24;
  localparam longint MaxValue = (longint'(1) << (NB - 1)) - 1;

  // One character beat on the output side.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_beat_t;

  // One number waiting to go out, with a flag that makes the sender hold
  // it back until every character already owed has arrived.
  typedef struct packed {
    logic signed [NB-1:0] number;
    logic                 drain_first;
  } number_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [NB-1:0] number_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [7:0]           character_o;
  logic                 last_o;

  number_beat_t numbers_to_send[$];
  char_beat_t   text_expected[$];
  number_beat_t next_number;
  char_beat_t   oldest_char;
  int           error_count = 0;
  int           send_idle_pct = 22;
  int           recv_idle_pct = 50;

  signed_int_to_decimal_ascii_core #(
    .NumberBits(NB)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .number_i   (number_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Appends the decimal text of one number to the characters still owed.
  // The magnitude is one bit wider than the number, so the most negative
  // value negates without overflow.
  function automatic void predict_decimal_text(input logic signed [NB-1:0] value);
    logic [NB:0] magnitude;
    logic [3:0]  digit_buf[DigitRoom];
    int          digit_count;
    logic        negative;
    negative = value[NB-1];
    magnitude = negative ? -{value[NB-1], value} : {1'b0, value};
    digit_count = 0;
    do begin
      digit_buf[digit_count] = 4'(magnitude % 10);
      digit_count++;
      magnitude = magnitude / 10;
    end while (magnitude != 0 && digit_count < DigitRoom);
    if (negative) begin
      text_expected.push_back(char_beat_t'{character: itd_pkg::CHAR_MINUS, last: 1'b0});
    end
    for (int k = digit_count - 1; k >= 0; k--) begin
      text_expected.push_back(char_beat_t'{character: itd_pkg::CHAR_ZERO + 8'(digit_buf[k]),
                                           last: (k == 0)});
    end
  endfunction

  function automatic longint pow10(input int exponent);
    longint product;
    product = 1;
    repeat (exponent) product = product * 10;
    return product;
  endfunction

  // Mixes full-width words with values spread evenly over the digit counts,
  // so that short texts and sign handling show up often.
  function automatic logic signed [NB-1:0] draw_number();
    longint magnitude;
    longint lo;
    longint hi;
    int     digits;
    int     pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      return $urandom;
    end else if (pick < 55) begin
      magnitude = $urandom_range(999);
    end else if (pick < 85) begin
      digits = $urandom_range(1, 10);
      lo = (digits == 1) ? 0 : pow10(digits - 1);
      hi = pow10(digits) - 1;
      if (hi > MaxValue) begin
        hi = MaxValue;
      end
      magnitude = lo + $urandom_range(32'(hi - lo));
    end else begin
      case ($urandom_range(3))
        0: magnitude = MaxValue;
        1: magnitude = MaxValue + 1;
        2: magnitude = pow10($urandom_range(9));
        default: magnitude = pow10($urandom_range(1, 9)) - 1;
      endcase
    end
    if ($urandom_range(1) == 1) begin
      magnitude = -magnitude;
    end
    return magnitude[NB-1:0];
  endfunction

  task automatic queue_number(input longint value, input bit drain_first);
    numbers_to_send.push_back(number_beat_t'{number: value[NB-1:0],
                                             drain_first: drain_first});
  endtask

  task automatic wait_until_sent();
    while (numbers_to_send.size() != 0 || in_valid_i) @(posedge clk_i);
  endtask

  // Sender: the expected text of a number is recorded in the cycle its beat
  // is accepted. A new number goes out only when no beat is being held.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_decimal_text(number_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (numbers_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(numbers_to_send[0].drain_first && text_expected.size() != 0)) begin
          next_number = numbers_to_send.pop_front();
          in_valid_i <= 1'b1;
          number_i <= next_number.number;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: each accepted character beat is checked against the oldest
  // one owed, field by field.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (text_expected.size() == 0) begin
          error_count++;
          $display("%0t: expected no character, got character %0d last %0b",
                   $time, character_o, last_o);
        end else begin
          oldest_char = text_expected.pop_front();
          if (character_o !== oldest_char.character) begin
            error_count++;
            $display("%0t: character mismatch, expected %0d, got %0d",
                     $time, oldest_char.character, character_o);
          end
          if (last_o !== oldest_char.last) begin
            error_count++;
            $display("%0t: last mismatch, expected %0b, got %0b",
                     $time, oldest_char.last, last_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    // Directed numbers: zero, single digits, digit-count boundaries and both
    // ends of the range, including the most negative value.
    queue_number(0, 1'b0);
    queue_number(1, 1'b0);
    queue_number(-1, 1'b0);
    queue_number(9, 1'b0);
    queue_number(-9, 1'b0);
    queue_number(10, 1'b0);
    queue_number(-10, 1'b0);
    queue_number(99, 1'b0);
    queue_number(100, 1'b0);
    queue_number(-100, 1'b0);
    queue_number(MaxValue, 1'b0);
    queue_number(-MaxValue - 1, 1'b0);
    queue_number(-MaxValue, 1'b1);
    queue_number(MaxValue - 1, 1'b0);
    queue_number(1000000000, 1'b0);
    queue_number(-1000000000, 1'b0);
    queue_number(999999999, 1'b0);
    queue_number(-999999999, 1'b0);
    queue_number(1234567890, 1'b0);
    queue_number(-1234567890, 1'b0);
    queue_number(0, 1'b0);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int n = 0; n < 110; n++) begin
      queue_number(draw_number(), $urandom_range(49) == 0);
    end
    wait_until_sent();

    send_idle_pct = 50;
    recv_idle_pct = 22;
    // The first number of this stretch waits until the output is fully drained.
    queue_number(draw_number(), 1'b1);
    for (int n = 0; n < 110; n++) begin
      queue_number(draw_number(), $urandom_range(49) == 0);
    end
    wait_until_sent();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 110; n++) begin
      queue_number(draw_number(), 1'b0);
    end
    wait_until_sent();

    while (text_expected.size() != 0) @(posedge clk_i);
    // Anything the block still emits after this point has no expectation.
    repeat (64) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/itd_pkg.sv
hw/rtl/itd_ctrl.sv
hw/rtl/itd_dp.sv
hw/rtl/signed_int_to_decimal_ascii_core.sv
dv/signed_int_to_decimal_ascii_core_tb.sv
